// ----- rtl/core/nfv5_pkg.sv -----
package nfv5_pkg;

    localparam logic MODE_HEADER = 1'b0;
    localparam logic MODE_FLOW   = 1'b1;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_INTERVAL   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FORCED_SAMPLING = 2'd1;

    localparam logic [7:0]  ICMP_PROTO    = 8'd1;
    localparam logic [31:0] WRAP_WINDOW   = 32'd100000;
    localparam logic [31:0] MS_PER_S      = 32'd1000;
    // ceil(2^50 / 10^6): exact quotient for any 32-bit dividend
    localparam logic [31:0] NS_TO_MS_RECIP = 32'd1125899907;
    localparam int          NS_TO_MS_SHIFT = 50;
    localparam int          MS_QUOT_W      = 13;
    localparam int          SAMPLE_W       = 14;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        kind;
        logic        header_error;
        logic        sequence_gap;
        logic [31:0] gap_total;
        logic        sampled;
        logic [31:0] interval;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [31:0] word_d;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [1:0]  start_wraps;
        logic        end_wrap;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- rtl/core/nfv5_front.sv -----
module nfv5_front #(
    parameter int unsigned MAX_RECORDS = 30
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [nfv5_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  logic                           mode,
    input  logic [31:0]                    word_a,
    input  logic [31:0]                    word_b,
    input  logic [31:0]                    word_c,
    input  logic [31:0]                    word_d,
    input  logic [15:0]                    half_a,
    input  logic [15:0]                    half_b,
    input  logic [7:0]                     protocol,
    input  nfv5_pkg::queue_status_t        q_status,
    output logic                           q_push,
    output nfv5_pkg::entry_t               q_entry
);

    logic [31:0] base_interval_reg;
    logic [31:0] forced_sampling_reg;
    logic        seen_header_reg,   seen_header_next;
    logic        header_valid_reg,  header_valid_next;
    logic        seq_seeded_reg,    seq_seeded_next;
    logic [31:0] prev_sequence_reg, prev_sequence_next;
    logic [15:0] prev_count_reg,    prev_count_next;
    logic [31:0] failure_count_reg, failure_count_next;
    logic [31:0] uptime_ms_reg,     uptime_ms_next;
    logic [31:0] interval_reg,      interval_next;

    logic        accept;
    logic [31:0] hdr_interval;
    logic [31:0] seq_dist;
    logic [31:0] up_diff;
    logic        late_wrap;
    logic        first_after_last;
    logic        icmp_fix;

    assign item_ready = !q_status.full;
    assign accept     = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_interval_reg   <= 32'd1;
            forced_sampling_reg <= 32'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                nfv5_pkg::REG_BASE_INTERVAL:   base_interval_reg   <= cfg_data;
                nfv5_pkg::REG_FORCED_SAMPLING: forced_sampling_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        hdr_interval = {{(32-nfv5_pkg::SAMPLE_W){1'b0}}, half_b[nfv5_pkg::SAMPLE_W-1:0]};
        if (hdr_interval == 32'd0)
            hdr_interval = base_interval_reg;
        if (forced_sampling_reg != 32'd0)
            hdr_interval = forced_sampling_reg;
    end

    assign seq_dist         = word_a - prev_sequence_reg;
    assign up_diff          = word_b - uptime_ms_reg;
    assign late_wrap        = (word_b > uptime_ms_reg) && (up_diff > nfv5_pkg::WRAP_WINDOW);
    assign first_after_last = word_a > word_b;
    assign icmp_fix         = (protocol == nfv5_pkg::ICMP_PROTO) && (half_a != 16'd0);

    always_comb
    begin
        seen_header_next   = seen_header_reg;
        header_valid_next  = header_valid_reg;
        seq_seeded_next    = seq_seeded_reg;
        prev_sequence_next = prev_sequence_reg;
        prev_count_next    = prev_count_reg;
        failure_count_next = failure_count_reg;
        uptime_ms_next     = uptime_ms_reg;
        interval_next      = interval_reg;
        q_push             = 1'b0;

        q_entry              = '0;
        q_entry.kind         = mode;
        q_entry.interval     = interval_reg;
        q_entry.word_a       = word_a;
        q_entry.word_b       = word_b;
        q_entry.word_c       = word_c;
        q_entry.word_d       = word_d;
        q_entry.gap_total    = failure_count_reg;

        if (mode == nfv5_pkg::MODE_HEADER)
        begin
            q_push = accept;
            if (!seen_header_reg)
            begin
                interval_next    = hdr_interval;
                seen_header_next = 1'b1;
            end
            if (half_a > 16'(MAX_RECORDS))
            begin
                header_valid_next    = 1'b0;
                q_entry.header_error = 1'b1;
            end
            else
            begin
                if (!seq_seeded_reg)
                    seq_seeded_next = 1'b1;
                else if (seq_dist != {16'd0, prev_count_reg})
                begin
                    q_entry.sequence_gap = 1'b1;
                    if (failure_count_reg != 32'hffff_ffff)
                        failure_count_next = failure_count_reg + 32'd1;
                end
                prev_sequence_next = word_a;
                prev_count_next    = half_a;
                uptime_ms_next     = word_b;
                header_valid_next  = 1'b1;
                q_entry.gap_total  = failure_count_next;
            end
        end
        else
        begin
            q_push              = accept && header_valid_reg;
            q_entry.sampled     = interval_reg != 32'd1;
            q_entry.source_port = icmp_fix ? 16'd0 : half_a;
            q_entry.dest_port   = icmp_fix ? {half_a[7:0], half_a[15:8]} : half_b;
            q_entry.start_wraps = {1'b0, first_after_last} + {1'b0, late_wrap};
            q_entry.end_wrap    = late_wrap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_header_reg   <= 1'b0;
            header_valid_reg  <= 1'b0;
            seq_seeded_reg    <= 1'b0;
            prev_sequence_reg <= 32'd0;
            prev_count_reg    <= 16'd0;
            failure_count_reg <= 32'd0;
            uptime_ms_reg     <= 32'd0;
            interval_reg      <= 32'd1;
        end
        else if (accept)
        begin
            seen_header_reg   <= seen_header_next;
            header_valid_reg  <= header_valid_next;
            seq_seeded_reg    <= seq_seeded_next;
            prev_sequence_reg <= prev_sequence_next;
            prev_count_reg    <= prev_count_next;
            failure_count_reg <= failure_count_next;
            uptime_ms_reg     <= uptime_ms_next;
            interval_reg      <= interval_next;
        end
    end

endmodule

// ----- rtl/core/nfv5_queue.sv -----
module nfv5_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  nfv5_pkg::entry_t        push_entry,
    input  logic                    pop,
    output nfv5_pkg::entry_t        head_entry,
    output nfv5_pkg::queue_status_t status
);

    nfv5_pkg::entry_t entries_reg [nfv5_pkg::QUEUE_DEPTH];

    logic [nfv5_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [nfv5_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [nfv5_pkg::QUEUE_CNT_W-1:0] count_reg,  count_next;

    assign status.full  = count_reg == nfv5_pkg::QUEUE_CNT_W'(nfv5_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign head_entry   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == nfv5_pkg::QUEUE_PTR_W'(nfv5_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            if (rd_ptr_reg == nfv5_pkg::QUEUE_PTR_W'(nfv5_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ----- rtl/core/nfv5_back.sv -----
module nfv5_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  nfv5_pkg::entry_t        head_entry,
    input  nfv5_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    result_valid,
    input  logic                    result_ready,
    output logic                    kind,
    output logic                    header_error,
    output logic                    sequence_gap,
    output logic [31:0]             gap_total,
    output logic [63:0]             start_ms,
    output logic [63:0]             end_ms,
    output logic [15:0]             source_port,
    output logic [15:0]             dest_port,
    output logic [63:0]             packets_out,
    output logic [63:0]             bytes_out,
    output logic                    sampled
);

    // stage A: products
    logic             a_valid_reg;
    nfv5_pkg::entry_t a_entry_reg;
    logic [63:0]      a_prod_c_reg, a_prod_c_next;
    logic [63:0]      a_prod_d_reg, a_prod_d_next;
    logic             a_advance;

    logic [31:0]      mul_c;
    logic [31:0]      mul_d;

    logic [63:0]      boot_ms_reg, boot_ms_next;
    logic [63:0]      start_off;
    logic [63:0]      end_off;

    logic             out_valid_reg;
    logic             out_kind_reg;
    logic             out_err_reg;
    logic             out_gap_reg;
    logic [31:0]      out_gap_total_reg;
    logic [63:0]      out_start_reg, out_start_next;
    logic [63:0]      out_end_reg,   out_end_next;
    logic [15:0]      out_sport_reg;
    logic [15:0]      out_dport_reg;
    logic [63:0]      out_packets_reg;
    logic [63:0]      out_bytes_reg;
    logic             out_sampled_reg;
    logic             is_flow;

    assign a_advance = a_valid_reg && (!out_valid_reg || result_ready);
    assign pop       = !q_status.empty && (!a_valid_reg || a_advance);

    always_comb
    begin
        if (head_entry.kind == nfv5_pkg::MODE_FLOW)
        begin
            mul_c = head_entry.interval;
            mul_d = head_entry.interval;
        end
        else
        begin
            mul_c = nfv5_pkg::MS_PER_S;
            mul_d = nfv5_pkg::NS_TO_MS_RECIP;
        end
        a_prod_c_next = {32'd0, head_entry.word_c} * {32'd0, mul_c};
        a_prod_d_next = {32'd0, head_entry.word_d} * {32'd0, mul_d};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (pop)
            a_valid_reg <= 1'b1;
        else if (a_advance)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_entry_reg  <= head_entry;
            a_prod_c_reg <= a_prod_c_next;
            a_prod_d_reg <= a_prod_d_next;
        end
    end

    // boot time = s * 1000 + ns / 1e6 - uptime; a flow offset drops 2^32 per wrap
    assign is_flow      = a_entry_reg.kind == nfv5_pkg::MODE_FLOW;
    assign boot_ms_next = a_prod_c_reg
                        + {{(64-nfv5_pkg::MS_QUOT_W){1'b0}},
                           a_prod_d_reg[nfv5_pkg::NS_TO_MS_SHIFT +: nfv5_pkg::MS_QUOT_W]}
                        - {32'd0, a_entry_reg.word_b};
    assign start_off      = {32'd0 - {30'd0, a_entry_reg.start_wraps}, a_entry_reg.word_a};
    assign end_off        = {32'd0 - {31'd0, a_entry_reg.end_wrap}, a_entry_reg.word_b};
    assign out_start_next = is_flow ? boot_ms_reg + start_off : 64'd0;
    assign out_end_next   = is_flow ? boot_ms_reg + end_off : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_ms_reg   <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_advance && !is_flow && !a_entry_reg.header_error)
                boot_ms_reg <= boot_ms_next;
            if (a_advance)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_advance)
        begin
            out_kind_reg      <= a_entry_reg.kind;
            out_err_reg       <= a_entry_reg.header_error;
            out_gap_reg       <= a_entry_reg.sequence_gap;
            out_gap_total_reg <= a_entry_reg.gap_total;
            out_start_reg     <= out_start_next;
            out_end_reg       <= out_end_next;
            out_sport_reg     <= a_entry_reg.source_port;
            out_dport_reg     <= a_entry_reg.dest_port;
            out_packets_reg   <= is_flow ? a_prod_c_reg : 64'd0;
            out_bytes_reg     <= is_flow ? a_prod_d_reg : 64'd0;
            out_sampled_reg   <= a_entry_reg.sampled;
        end
    end

    assign result_valid = out_valid_reg;
    assign kind         = out_kind_reg;
    assign header_error = out_err_reg;
    assign sequence_gap = out_gap_reg;
    assign gap_total    = out_gap_total_reg;
    assign start_ms     = out_start_reg;
    assign end_ms       = out_end_reg;
    assign source_port  = out_sport_reg;
    assign dest_port    = out_dport_reg;
    assign packets_out  = out_packets_reg;
    assign bytes_out    = out_bytes_reg;
    assign sampled      = out_sampled_reg;

endmodule

// ----- rtl/core/netflow_v5_record_decoder_core.sv -----
// channel   | valid/ready                | payload
// ----------+----------------------------+-----------------------------------------
// item      | item_valid / item_ready    | mode, word_a..word_d, half_a, half_b, protocol
// result    | result_valid / result_ready| kind, header_error, sequence_gap, gap_total, ...
// config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One request per cycle sustained while result_ready stays high; through an empty queue
// a request is written to the queue at the accepting edge, then registered in the
// multiply stage, then in the sum stage, whose registers form the result register.
// The back end's two 32x32 multipliers and 64-bit sums set the per-request time.
// Reset clears header state, interval to 1, base interval to 1, forced_sampling to 0.
// A stalled result holds the back end; the front keeps accepting until the queue fills.
// Records arriving without a valid header are dropped in the front end.
module netflow_v5_record_decoder_core #(
    parameter int unsigned MAX_RECORDS = 30
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [nfv5_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  logic                             mode,
    input  logic [31:0]                      word_a,
    input  logic [31:0]                      word_b,
    input  logic [31:0]                      word_c,
    input  logic [31:0]                      word_d,
    input  logic [15:0]                      half_a,
    input  logic [15:0]                      half_b,
    input  logic [7:0]                       protocol,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic                             kind,
    output logic                             header_error,
    output logic                             sequence_gap,
    output logic [31:0]                      gap_total,
    output logic [63:0]                      start_ms,
    output logic [63:0]                      end_ms,
    output logic [15:0]                      source_port,
    output logic [15:0]                      dest_port,
    output logic [63:0]                      packets_out,
    output logic [63:0]                      bytes_out,
    output logic                             sampled
);

    nfv5_pkg::queue_status_t q_status;
    nfv5_pkg::entry_t        q_push_entry;
    nfv5_pkg::entry_t        q_head_entry;
    logic                    q_push;
    logic                    q_pop;

    assign cfg_ready = 1'b1;

    nfv5_front #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .mode       (mode),
        .word_a     (word_a),
        .word_b     (word_b),
        .word_c     (word_c),
        .word_d     (word_d),
        .half_a     (half_a),
        .half_b     (half_b),
        .protocol   (protocol),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_entry    (q_push_entry)
    );

    nfv5_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head_entry (q_head_entry),
        .status     (q_status)
    );

    nfv5_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_entry   (q_head_entry),
        .q_status     (q_status),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .header_error (header_error),
        .sequence_gap (sequence_gap),
        .gap_total    (gap_total),
        .start_ms     (start_ms),
        .end_ms       (end_ms),
        .source_port  (source_port),
        .dest_port    (dest_port),
        .packets_out  (packets_out),
        .bytes_out    (bytes_out),
        .sampled      (sampled)
    );

`ifndef SYNTH
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty) && !(q_pop && q_status.empty))
        else $error("queue status inconsistent");

    a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && header_error |-> kind == nfv5_pkg::MODE_HEADER && !sequence_gap)
        else $error("rejected header carries flow or gap");

    a_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == nfv5_pkg::MODE_HEADER |->
            start_ms == 64'd0 && end_ms == 64'd0 && packets_out == 64'd0 &&
            bytes_out == 64'd0 && !sampled)
        else $error("header result carries flow fields");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !item_ready)
        else $error("item taken while queue full");
`endif

endmodule
